[sv/rle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_pkg: shared types and constants of the route length evaluator
// widths of the coordinate, square, root and length datapaths, command codes
// and the sequencer state type
// ----------------------------------------------------------------------------
package rle_pkg;

    // default table depth
    localparam int MAX_CITIES_DEF = 256;

    // word field widths
    localparam int CITY_W  = 8;
    localparam int COORD_W = 16;
    localparam int ENTRY_W = 2 * COORD_W;

    // |dx|, |dy| fit in the coordinate width, the sum of squares in twice that plus one bit
    localparam int MAG_W  = COORD_W;
    localparam int SUM_W  = 2 * MAG_W + 1;

    // radicand is the sum shifted up by twice the fractional bits
    localparam int FRAC_W    = 8;
    localparam int RAD_W     = SUM_W + 1;
    localparam int ROOT_W    = (SUM_W + 2 * FRAC_W + 1) / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int LEN_W     = 33;

    // step counts of the serial units
    localparam int SQ_STEPS   = MAG_W;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int CNT_W      = 5;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_VISIT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQUARE,
        ST_ROOT,
        ST_ACCUM,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

[sv/route_length_evaluator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// route_length_evaluator: euclidean length of an open route through cities
// load words fill a coordinate table, visit words walk a route and a visit
// marked last returns the total length in unsigned q25.8, saturating
// ----------------------------------------------------------------------------
//
//   channel   ports                                       role
//   s_        s_valid s_ready s_cmd s_city s_xpos s_ypos   command word in
//             s_last
//   m_        m_valid m_ready m_length                    route length word out
//
// a load word is written while idle. a visit word runs a table read and a
// difference step; later visits of a route then run a bit-serial squarer,
// a bit-pair square root (the longer loop) and an accumulate step, and no
// word is taken until a visit is done. the first visit of a route skips
// to done after the difference step. reset clears the sequencer, the route
// state and the output slot; the city table is not cleared. a finished
// length waits in the output register, and only a further last visit stalls
// (in its final cycle) until that is taken.
module route_length_evaluator
    import rle_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,

    input  wire                 s_valid,
    output logic                s_ready,
    input  wire                 s_cmd,
    input  wire  [CITY_W-1:0]   s_city,
    input  wire  [COORD_W-1:0]  s_xpos,
    input  wire  [COORD_W-1:0]  s_ypos,
    input  wire                 s_last,

    output logic                m_valid,
    input  wire                 m_ready,
    output logic [LEN_W-1:0]    m_length
);

    localparam int IDX_W = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int MOD_W = IDX_W + 1;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t               state_reg, state_next;
    logic                 started_reg, started_next;
    logic                 last_reg, last_next;
    logic [LEN_W-1:0]     acc_reg, acc_next;
    logic [ENTRY_W-1:0]   prev_reg, prev_next;
    logic [ENTRY_W-1:0]   rd_data_reg;

    // serial squarer: multiplicands shift up, multipliers shift down
    logic [SUM_W-1:0]     mcx_reg, mcx_next;
    logic [SUM_W-1:0]     mcy_reg, mcy_next;
    logic [MAG_W-1:0]     mpx_reg, mpx_next;
    logic [MAG_W-1:0]     mpy_reg, mpy_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;

    // serial square root: radicand leaves two bits a step from the top
    logic [RAD_W-1:0]     rad_reg, rad_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]    root_reg, root_next;

    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic                 m_valid_reg, m_valid_next;
    logic [LEN_W-1:0]     m_length_reg, m_length_next;

    // table storage, contents undefined until loaded
    logic [ENTRY_W-1:0]   city_mem [MAX_CITIES];

    // ------------------------------------------------------------------
    // handshake decode
    // ------------------------------------------------------------------
    logic                 in_fire;
    logic                 load_we;
    logic                 visit_re;
    logic                 emit;
    logic                 out_free;

    assign in_fire  = s_valid && s_ready;
    assign load_we  = in_fire && (s_cmd == CMD_LOAD);
    assign visit_re = in_fire && (s_cmd == CMD_VISIT);
    assign out_free = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // city index wrapped into the table depth, one restoring step a bit
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]     idx;

    always_comb begin
        logic [MOD_W-1:0] rem;
        rem = '0;
        for (int i = CITY_W - 1; i >= 0; i--) begin
            rem = {rem[MOD_W-2:0], s_city[i]};
            if (rem >= MOD_W'(MAX_CITIES)) begin
                rem = rem - MOD_W'(MAX_CITIES);
            end
        end
        idx = rem[IDX_W-1:0];
    end

    // table write on load, registered read on visit
    always_ff @(posedge aclk) begin
        if (load_we) begin
            city_mem[idx] <= {s_ypos, s_xpos};
        end
        if (visit_re) begin
            rd_data_reg <= city_mem[idx];
        end
    end

    // ------------------------------------------------------------------
    // coordinate differences of the visited city against the previous one
    // ------------------------------------------------------------------
    logic [COORD_W:0]     dx_s, dy_s;
    logic [MAG_W-1:0]     dx_mag, dy_mag;

    always_comb begin
        dx_s = {rd_data_reg[COORD_W-1], rd_data_reg[COORD_W-1:0]}
             - {prev_reg[COORD_W-1], prev_reg[COORD_W-1:0]};
        dy_s = {rd_data_reg[ENTRY_W-1], rd_data_reg[ENTRY_W-1:COORD_W]}
             - {prev_reg[ENTRY_W-1], prev_reg[ENTRY_W-1:COORD_W]};
        dx_mag = dx_s[COORD_W] ? MAG_W'(-dx_s) : dx_s[MAG_W-1:0];
        dy_mag = dy_s[COORD_W] ? MAG_W'(-dy_s) : dy_s[MAG_W-1:0];
    end

    // ------------------------------------------------------------------
    // square root step: trial remainder against {root, 01}
    // ------------------------------------------------------------------
    logic [REM_W+1:0]     trial;
    logic [REM_W+1:0]     probe;
    logic                 root_bit;

    assign trial    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign probe    = (REM_W + 2)'({root_reg, 2'b01});
    assign root_bit = (trial >= probe);

    // accumulate with saturation at the top of the length range
    logic [LEN_W:0]       acc_sum;

    assign acc_sum = {1'b0, acc_reg} + (LEN_W + 1)'(root_reg);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (visit_re) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                state_next = started_reg ? ST_SQUARE : ST_DONE;
            end
            ST_SQUARE: begin
                if (cnt_reg == '0) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (cnt_reg == '0) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!last_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // state outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready = 1'b0;
        emit    = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_DONE: emit    = last_reg && out_free;
            default: begin
                s_ready = 1'b0;
                emit    = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        started_next  = started_reg;
        last_next     = last_reg;
        acc_next      = acc_reg;
        prev_next     = prev_reg;
        mcx_next      = mcx_reg;
        mcy_next      = mcy_reg;
        mpx_next      = mpx_reg;
        mpy_next      = mpy_reg;
        sum_next      = sum_reg;
        rad_next      = rad_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        cnt_next      = cnt_reg;
        m_length_next = m_length_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        if (visit_re) begin
            last_next = s_last;
        end

        case (state_reg)
            ST_DIFF: begin
                prev_next = rd_data_reg;
                if (!started_reg) begin
                    // first city of a route only records its position
                    started_next = 1'b1;
                    acc_next     = '0;
                end else begin
                    mcx_next = SUM_W'(dx_mag);
                    mcy_next = SUM_W'(dy_mag);
                    mpx_next = dx_mag;
                    mpy_next = dy_mag;
                    sum_next = '0;
                    cnt_next = CNT_W'(SQ_STEPS - 1);
                end
            end
            ST_SQUARE: begin
                sum_next = sum_reg + (mpx_reg[0] ? mcx_reg : '0)
                                   + (mpy_reg[0] ? mcy_reg : '0);
                mcx_next = {mcx_reg[SUM_W-2:0], 1'b0};
                mcy_next = {mcy_reg[SUM_W-2:0], 1'b0};
                mpx_next = {1'b0, mpx_reg[MAG_W-1:1]};
                mpy_next = {1'b0, mpy_reg[MAG_W-1:1]};
                if (cnt_reg == '0) begin
                    rad_next  = {1'b0, sum_next};
                    rem_next  = '0;
                    root_next = '0;
                    cnt_next  = CNT_W'(ROOT_STEPS - 1);
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_ROOT: begin
                rem_next  = root_bit ? REM_W'(trial - probe) : REM_W'(trial);
                root_next = {root_reg[ROOT_W-2:0], root_bit};
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_ACCUM: begin
                acc_next = acc_sum[LEN_W] ? {LEN_W{1'b1}} : acc_sum[LEN_W-1:0];
            end
            ST_DONE: begin
                if (emit) begin
                    m_length_next = acc_reg;
                    m_valid_next  = 1'b1;
                    acc_next      = '0;
                    started_next  = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            acc_reg     <= '0;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
            acc_reg     <= acc_next;
            prev_reg    <= prev_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        last_reg     <= last_next;
        mcx_reg      <= mcx_next;
        mcy_reg      <= mcy_next;
        mpx_reg      <= mpx_next;
        mpy_reg      <= mpy_next;
        sum_reg      <= sum_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        m_length_reg <= m_length_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_length = m_length_reg;

endmodule
`default_nettype wire

[test/tb_route_length_evaluator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_route_length_evaluator: self-checking bench for the route length evaluator
// a queue of load and visit words feeds a valid/ready driver, a monitor on the
// length channel compares every length word with the one predicted from a
// coordinate table kept here, both sides idle at random and the receiver
// holds off once for a long stretch so the block backs up into its input
// ----------------------------------------------------------------------------
module tb_route_length_evaluator
    import rle_pkg::*;
();

    // one command word as the driver presents it
    typedef struct packed {
        logic               cmd;
        logic [CITY_W-1:0]  city;
        logic [COORD_W-1:0] xpos;
        logic [COORD_W-1:0] ypos;
        logic               last;
    } route_word_t;

    localparam int          NUM_CITIES   = MAX_CITIES_DEF;
    localparam logic [63:0] LEN_MAX      = (64'd1 << LEN_W) - 64'd1;
    localparam int          WORD_TARGET  = 1750;
    // a full-diagonal leg is about 23.7e6 in q.8, so ~363 legs saturate
    localparam int          SAT_VISITS   = 372;
    // long receiver hold-off, started once this many words went in
    localparam int          HOLD_AT      = 600;
    localparam int          HOLD_CYCLES  = 1500;
    // the longest visit is far shorter than this, so this is a wide margin for the tail
    localparam int          DRAIN_CYCLES = 150;
    // slowest run: ~1800 words x (longest visit + widest send gap + stall) + hold-off,
    // taken several times over
    localparam int          CYCLE_LIMIT  = 600000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_cmd = CMD_LOAD;
    logic [CITY_W-1:0]  s_city = '0;
    logic [COORD_W-1:0] s_xpos = '0;
    logic [COORD_W-1:0] s_ypos = '0;
    logic               s_last = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [LEN_W-1:0]   m_length;

    // stimulus and scoreboard
    route_word_t        pending_words[$];
    logic [LEN_W-1:0]   expected_lengths[$];
    byte unsigned       loaded_cities[$];
    bit                 city_loaded[NUM_CITIES];

    // predictor state: coordinate table, previous position, open route, total
    logic [2*COORD_W-1:0] city_xy[NUM_CITIES];
    logic [2*COORD_W-1:0] prev_xy = '0;
    bit                   route_open = 1'b0;
    logic [63:0]          route_total = '0;
    int                   route_hops = 0;

    // handshake flags sampled at the rising edge, used at the falling edge
    bit          s_took = 1'b0;
    bit          m_took = 1'b0;

    int          cycle_count = 0;
    int          mismatches = 0;
    int          words_accepted = 0;
    int          loads_seen = 0;
    int          visits_seen = 0;
    int          lengths_checked = 0;
    int          saturated_routes = 0;
    int          longest_route = 0;

    // driver / receiver idling
    int          send_gap = 0;
    bit          send_calm = 1'b0;
    int          take_stall = 0;
    bit          recv_calm = 1'b0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    route_word_t next_word;

    route_length_evaluator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_cmd    (s_cmd),
        .s_city   (s_city),
        .s_xpos   (s_xpos),
        .s_ypos   (s_ypos),
        .s_last   (s_last),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_length (m_length)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // floor square root, one result bit per pass
    function automatic logic [63:0] floor_sqrt(input logic [63:0] radicand);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = radicand;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // euclidean distance between two packed positions, q.8 truncated
    function automatic logic [63:0] leg_length_q8(input logic [2*COORD_W-1:0] from_xy,
                                                  input logic [2*COORD_W-1:0] to_xy);
        int          dx;
        int          dy;
        logic [63:0] ax;
        logic [63:0] ay;
        dx = $signed(from_xy[COORD_W-1:0]) - $signed(to_xy[COORD_W-1:0]);
        dy = $signed(from_xy[2*COORD_W-1:COORD_W]) - $signed(to_xy[2*COORD_W-1:COORD_W]);
        ax = 64'(dx < 0 ? -dx : dx);
        ay = 64'(dy < 0 ? -dy : dy);
        return floor_sqrt((ax * ax + ay * ay) << 16);
    endfunction

    // update the route state for one accepted word, queue a length on last
    task automatic predict_route_word(input route_word_t w);
        int unsigned          idx;
        logic [2*COORD_W-1:0] here;
        idx = w.city % NUM_CITIES;
        if (w.cmd == CMD_LOAD) begin
            // last on a load is ignored and an open route is left alone
            city_xy[idx] = {w.ypos, w.xpos};
            loads_seen++;
        end else begin
            here = city_xy[idx];
            visits_seen++;
            if (!route_open) begin
                route_total = '0;
                route_open  = 1'b1;
                route_hops  = 0;
            end else begin
                route_total = route_total + leg_length_q8(prev_xy, here);
                if (route_total > LEN_MAX)
                    route_total = LEN_MAX;
                route_hops++;
            end
            prev_xy = here;
            if (w.last) begin
                expected_lengths.push_back(route_total[LEN_W-1:0]);
                if (route_total == LEN_MAX)
                    saturated_routes++;
                if (route_hops > longest_route)
                    longest_route = route_hops;
                route_total = '0;
                route_open  = 1'b0;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------

    task automatic push_load(input int city, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input bit last);
        route_word_t w;
        w.cmd  = CMD_LOAD;
        w.city = city[CITY_W-1:0];
        w.xpos = x;
        w.ypos = y;
        w.last = last;
        pending_words.push_back(w);
        if (!city_loaded[city % NUM_CITIES]) begin
            city_loaded[city % NUM_CITIES] = 1'b1;
            loaded_cities.push_back(byte'(city % NUM_CITIES));
        end
    endtask

    // coordinates of a visit are unused, so they carry random bits
    task automatic push_visit(input int city, input bit last);
        route_word_t w;
        w.cmd  = CMD_VISIT;
        w.city = city[CITY_W-1:0];
        w.xpos = COORD_W'($urandom);
        w.ypos = COORD_W'($urandom);
        w.last = last;
        pending_words.push_back(w);
    endtask

    // half full-range values, the rest corners and short distances
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2, 3:    return COORD_W'($urandom_range(0, 16) - 8);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // only cities that some load has written are ever visited
    function automatic int pick_loaded_city();
        return loaded_cities[$urandom_range(0, loaded_cities.size() - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // input driver: changes at the falling edge, one word at a time
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && !s_took) begin
                // word still waiting for ready, hold it
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                next_word = pending_words.pop_front();
                s_cmd   <= next_word.cmd;
                s_city  <= next_word.city;
                s_xpos  <= next_word.xpos;
                s_ypos  <= next_word.ypos;
                s_last  <= next_word.last;
                s_valid <= 1'b1;
                // now and then switch between idling and back-to-back words
                if ($urandom_range(0, 99) == 0)
                    send_calm = !send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, 4);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long hold-off on the length channel, counted in its own process
    always @(negedge aclk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && words_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // receiver: a fresh stall after every length word taken
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_took) begin
                if ($urandom_range(0, 99) == 0)
                    recv_calm = !recv_calm;
                take_stall = recv_calm ? 0 : $urandom_range(0, 4);
            end else if (take_stall > 0) begin
                take_stall--;
            end
            m_ready <= (take_stall == 0) && (hold_left == 0);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: samples both channels at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        s_took <= aresetn && s_valid && s_ready;
        m_took <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            predict_route_word({s_cmd, s_city, s_xpos, s_ypos, s_last});
            words_accepted <= words_accepted + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_lengths.size() == 0) begin
                report_mismatch($sformatf("length word 0x%0h with none expected", m_length));
            end else begin
                if (m_length !== expected_lengths[0])
                    report_mismatch($sformatf("length 0x%0h, expected 0x%0h",
                                              m_length, expected_lengths[0]));
                void'(expected_lengths.pop_front());
                lengths_checked++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL route_length_evaluator");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int hops;
        int i;

        // directed: corner coordinates, mid-route loads, short routes
        push_load(0,   16'h8000, 16'h8000, 1'b0);
        push_load(255, 16'h7fff, 16'h7fff, 1'b0);
        push_load(1,   16'h0000, 16'h0000, 1'b1);    // last on a load is ignored
        push_load(128, 16'h8000, 16'h7fff, 1'b0);
        push_load(2,   16'd3,    16'd4,    1'b0);
        push_visit(0, 1'b1);                         // single-city route gives zero
        push_visit(1, 1'b0);
        push_load(3, 16'hffff, 16'h0001, 1'b1);      // load inside an open route
        push_visit(2, 1'b0);                         // 3-4-5 leg
        push_visit(3, 1'b0);
        push_visit(1, 1'b1);
        push_visit(0, 1'b0);
        push_visit(255, 1'b0);                       // full diagonal
        push_visit(128, 1'b0);
        push_visit(0, 1'b1);
        push_visit(255, 1'b0);
        push_visit(255, 1'b1);                       // zero-length leg
        push_load(2, 16'd12345, 16'hA460, 1'b0);     // overwrite a city
        push_visit(2, 1'b0);
        push_visit(1, 1'b1);

        // one route long enough to drive the total into saturation
        for (i = 0; i < SAT_VISITS; i++)
            push_visit((i % 2) ? 255 : 0, i == SAT_VISITS - 1);

        // random: mostly well-formed routes, some bursts of bare loads
        while (pending_words.size() < WORD_TARGET) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4))
                    push_load($urandom_range(0, NUM_CITIES - 1), pick_coord(), pick_coord(),
                              1'($urandom_range(0, 1)));
            end else begin
                hops = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24)
                                                   : $urandom_range(1, 8);
                for (i = 0; i < hops; i++) begin
                    if ($urandom_range(0, 7) == 0)
                        push_load($urandom_range(0, NUM_CITIES - 1), pick_coord(),
                                  pick_coord(), 1'($urandom_range(0, 1)));
                    push_visit(pick_loaded_city(), i == hops - 1);
                end
            end
        end

        // reset once, released at a falling edge
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // wait for the queue to empty and every length to come back
        while (pending_words.size() != 0 || s_valid || expected_lengths.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        while (expected_lengths.size() != 0) begin
            report_mismatch($sformatf("length 0x%0h never arrived", expected_lengths[0]));
            void'(expected_lengths.pop_front());
        end

        $display("covered %0d words (%0d loads, %0d visits), %0d route lengths checked",
                 words_accepted, loads_seen, visits_seen, lengths_checked);
        $display("longest route %0d legs, %0d saturated totals, long output hold-off %s",
                 longest_route, saturated_routes, hold_done ? "done" : "not reached");
        if (mismatches == 0)
            $display("PASS route_length_evaluator");
        else
            $display("FAIL route_length_evaluator");
        $finish;
    end

endmodule

[sim.f]
sv/rle_pkg.sv
sv/route_length_evaluator.sv
test/tb_route_length_evaluator.sv
